// File: design/afcm_pkg.sv
// afcm_pkg: shared types and constants of the autorange false colour mapper
// beat payload structs, palette index width and the 64-entry colour palette
// no dependencies
package afcm_pkg;

  localparam int SampleWidth = 16;
  localparam int IdxBits     = 6;
  localparam int ColourBits  = 8;
  localparam int NumColours  = 1 << IdxBits;

  localparam logic [IdxBits-1:0] TopIndex = 6'd63;

  typedef struct packed {
    logic                   pass_select;
    logic [SampleWidth-1:0] sample;
    logic                   first_of_frame;
  } in_t;

  typedef struct packed {
    logic [IdxBits-1:0]    palette_index;
    logic [ColourBits-1:0] red;
    logic [ColourBits-1:0] green;
    logic [ColourBits-1:0] blue;
  } out_t;

  // black to white to red, packed as red, green, blue
  localparam logic [3*ColourBits-1:0] Palette [NumColours] = '{
    24'h000000, 24'h100707, 24'h20100E, 24'h301A15,
    24'h40231C, 24'h502C23, 24'h60352A, 24'h703E31,
    24'h80473A, 24'h904F41, 24'hA05848, 24'hB0614F,
    24'hC06A56, 24'hD0735D, 24'hE07C64, 24'hF0856B,
    24'hFF8E72, 24'hFF977A, 24'hFFA082, 24'hFFAA8A,
    24'hFFB391, 24'hFFBC99, 24'hFFC5A1, 24'hFFCEA9,
    24'hFFD7B0, 24'hFFE0B8, 24'hFFE9C0, 24'hFFF2C8,
    24'hFFFBD0, 24'hFFF4D9, 24'hFFEED2, 24'hFFE8CC,
    24'hFFE2C5, 24'hFFDDBC, 24'hFFD7B6, 24'hFFD1AF,
    24'hFFCBA9, 24'hFFC5A2, 24'hFFBFA5, 24'hFFB9A9,
    24'hFFB3AD, 24'hFFADA0, 24'hFFA79D, 24'hFFA196,
    24'hFF9B8F, 24'hFF9589, 24'hFF8F82, 24'hFF897C,
    24'hFF8375, 24'hFF7D6F, 24'hFF7768, 24'hFF7162,
    24'hFF6B5B, 24'hFF6555, 24'hFF5F4E, 24'hFF5948,
    24'hFF5341, 24'hFF4D3B, 24'hFF4734, 24'hFF412E,
    24'hFF3B27, 24'hFF351F, 24'hFF2F18, 24'hFF290D
  };

endpackage

// File: design/autorange_false_color_mapper_core.sv
// autorange_false_color_mapper_core: min/max tracking and palette mapping
// measure beat: taken whenever the core is idle, no result; map beat: sample registered,
// set-up state loads the divider, divider steps, finish state hands off to the output;
// clamped index: set-up, then hand-off, no divider; next beat after hand-off, which a stall holds
// reset: range min all ones, range max zero, no result pending
module autorange_false_color_mapper_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  afcm_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output afcm_pkg::out_t  out_data_o
);
  import afcm_pkg::*;

  localparam int NumBits = SAMPLE_BITS + IdxBits;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [SAMPLE_BITS-1:0] min_q, max_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [IdxBits-1:0]     idx_q, idx_d;
  logic                   out_valid_q;
  out_t                   out_q;

  logic                   in_acc;
  logic                   out_ld;
  logic [SAMPLE_BITS-1:0] smp_in;
  logic                   clamp_lo, clamp_hi;
  logic [SAMPLE_BITS-1:0] span, offs;
  logic [NumBits-1:0]     num;
  logic                   div_start, div_done;
  logic [IdxBits-1:0]     div_quo;

  assign in_acc = in_valid_i && (state_q == StIdle);
  assign smp_in = in_data_i.sample[SAMPLE_BITS-1:0];
  assign out_ld = (state_q == StFin) && (!out_valid_q || !out_stall_i);

  assign clamp_lo  = (max_q <= min_q) || (smp_q <= min_q);
  assign clamp_hi  = smp_q >= max_q;
  assign span      = max_q - min_q;
  assign offs      = smp_q - min_q;
  // offset times 63 as offset * 64 - offset
  assign num       = {offs, {IdxBits{1'b0}}} - {{IdxBits{1'b0}}, offs};
  assign div_start = (state_q == StPrep) && !clamp_lo && !clamp_hi;

  afcm_div #(
    .DEN_BITS(SAMPLE_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (span),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      StIdle: begin
        if (in_acc && in_data_i.pass_select) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        if (clamp_lo) begin
          idx_d   = '0;
          state_d = StFin;
        end else if (clamp_hi) begin
          idx_d   = TopIndex;
          state_d = StFin;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          idx_d   = div_quo;
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_ld) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      min_q       <= '1;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && !in_data_i.pass_select) begin
        if (in_data_i.first_of_frame) begin
          min_q <= smp_in;
          max_q <= smp_in;
        end else begin
          if (smp_in < min_q) begin
            min_q <= smp_in;
          end
          if (smp_in > max_q) begin
            max_q <= smp_in;
          end
        end
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q <= smp_in;
    end
    idx_q <= idx_d;
    if (out_ld) begin
      out_q.palette_index <= idx_q;
      out_q.red           <= Palette[idx_q][3*ColourBits-1:2*ColourBits];
      out_q.green         <= Palette[idx_q][2*ColourBits-1:ColourBits];
      out_q.blue          <= Palette[idx_q][ColourBits-1:0];
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // divider only reports completion while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider done outside divide state");

  // a frame restart collapses the range onto one sample
  a_first_collapses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_data_i.pass_select && in_data_i.first_of_frame)
    |=> (min_q == max_q))
    else $error("range not restarted on first beat");

  // a full, stalled output holds the finished index back
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StFin) && out_valid_q && out_stall_i) |=> (state_q == StFin))
    else $error("result dropped while output stalled");

  // a map beat always enters set-up, a measure beat never leaves idle
  a_map_enters_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.pass_select) |=> (state_q == StPrep))
    else $error("map beat did not start set-up");

  // the divider starts only on a beat with an unclamped index
  a_start_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> ((smp_q > min_q) && (smp_q < max_q)))
    else $error("divider started on a clamped sample");

endmodule

// File: design/afcm_div.sv
// afcm_div: serial restoring divider, one quotient bit per cycle
// quotient is known to fit in IdxBits bits; depends on afcm_pkg
module afcm_div #(
  parameter int DEN_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [DEN_BITS+afcm_pkg::IdxBits-1:0]  num_i,
  input  logic [DEN_BITS-1:0]                    den_i,
  output logic                                   done_o,
  output logic [afcm_pkg::IdxBits-1:0]           quo_o
);
  import afcm_pkg::*;

  localparam int CntBits = $clog2(IdxBits + 1);

  logic                busy_q;
  logic [CntBits-1:0]  cnt_q;
  logic                done_q;
  logic [DEN_BITS-1:0] rem_q;
  logic [DEN_BITS-1:0] den_q;
  logic [IdxBits-1:0]  low_q;
  logic [IdxBits-1:0]  quo_q;

  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                ge;

  assign trial = {rem_q, low_q[IdxBits-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CntBits'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(IdxBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntBits'(1);
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[DEN_BITS+IdxBits-1:IdxBits];
      low_q <= num_i[IdxBits-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      low_q <= {low_q[IdxBits-2:0], 1'b0};
      quo_q <= {quo_q[IdxBits-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
